@@ sv/assert_macros.svh @@
// Assertion macros shared by the frustum culling RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge of clk_i, switched off while reset is low.
`define FC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("frustum cull assertion failed");
// Checked on every rising edge of clk_i, reset included.
`define FC_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("frustum cull assertion failed during reset");
`else
`define FC_ASSERT(lbl, prop)
`define FC_ASSERT_NR(lbl, prop)
`endif
`endif

@@ sv/fcull_pkg.sv @@
// Package with the constants and types of the frustum culling block.
package fcull_pkg;

  // Plane storage and field layout.
  localparam int NUM_PLANES       = 6;
  localparam int PLANE_W          = 64;
  localparam int FIELD_W          = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int D_SCALED_W       = FIELD_W + NORMAL_FRAC_BITS;
  localparam int NUM_AXES         = 3;

  // Default coordinate width.
  localparam int COORD_WIDTH_DEF  = 16;

  // Result stream: one pass bit, padded to a byte.
  localparam int OUT_TDATA_W      = 8;
  localparam int IN_TUSER_W       = 2;

  // Configuration register indexes.
  localparam int CFG_INDEX_W      = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_NEAR  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_FAR   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_LEFT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_RIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_UP    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_DOWN  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_Z_CHECK     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED      = 3'd7;

  // Plane slots in the plane array.
  localparam int PLANE_NEAR = 0;
  localparam int PLANE_FAR  = 1;

  // Test requested for a primitive.
  typedef enum logic [1:0] {
    KIND_POINT   = 2'd0,
    KIND_SPH_IN  = 2'd1,
    KIND_SPH_X   = 2'd2,
    KIND_BOX     = 2'd3
  } kind_e;

  // A configuration write request.
  typedef struct packed {
    logic                   wr;
    logic [CFG_INDEX_W-1:0] index;
    logic [PLANE_W-1:0]     data;
  } cfg_wr_t;

endpackage

@@ sv/fcull_cfg_regs.sv @@
// Configuration register file: six planes and the z check enable.
`include "assert_macros.svh"

module fcull_cfg_regs (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  input  fcull_pkg::cfg_wr_t                                      cfg_i,
  output logic [fcull_pkg::NUM_PLANES-1:0][fcull_pkg::PLANE_W-1:0] planes_o,
  output logic                                                    z_check_o
);
  import fcull_pkg::*;

  logic [NUM_PLANES-1:0][PLANE_W-1:0] planes_q, planes_d;
  logic                               z_check_q, z_check_d;

  // Decode the write request; indexes past the list are dropped.
  always_comb begin
    planes_d  = planes_q;
    z_check_d = z_check_q;
    if (cfg_i.wr) begin
      case (cfg_i.index)
        CFG_PLANE_NEAR, CFG_PLANE_FAR, CFG_PLANE_LEFT,
        CFG_PLANE_RIGHT, CFG_PLANE_UP, CFG_PLANE_DOWN: begin
          planes_d[cfg_i.index] = cfg_i.data;
        end
        CFG_Z_CHECK: begin
          z_check_d = cfg_i.data[0];
        end
        default: begin
          planes_d  = planes_q;
        end
      endcase
    end
  end

  // Planes clear to zero, z check comes up enabled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planes_q  <= '0;
      z_check_q <= 1'b1;
    end else begin
      planes_q  <= planes_d;
      z_check_q <= z_check_d;
    end
  end

  assign planes_o  = planes_q;
  assign z_check_o = z_check_q;

  `FC_ASSERT(a_z_write, cfg_i.wr && cfg_i.index == CFG_Z_CHECK |=> z_check_q == $past(cfg_i.data[0]))
  `FC_ASSERT(a_plane_write, cfg_i.wr && cfg_i.index < CFG_Z_CHECK |=> planes_q[$past(cfg_i.index)] == $past(cfg_i.data))
  `FC_ASSERT(a_unused_write, cfg_i.wr && cfg_i.index == CFG_UNUSED |=> $stable(planes_q) && $stable(z_check_q))

endmodule

@@ sv/fcull_plane_test.sv @@
// Signed distance of one primitive to one plane and the reject decision.
module fcull_plane_test #(
  parameter int COORD_WIDTH = fcull_pkg::COORD_WIDTH_DEF
) (
  input  logic [fcull_pkg::PLANE_W-1:0]                   plane_i,
  input  fcull_pkg::kind_e                                kind_i,
  input  logic [fcull_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] lo_i,
  input  logic [fcull_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] hi_i,
  input  logic [COORD_WIDTH-2:0]                          radius_i,
  output logic                                            reject_o
);
  import fcull_pkg::*;

  localparam int PROD_W = COORD_WIDTH + FIELD_W;
  localparam int DIST_W = ((PROD_W > D_SCALED_W) ? PROD_W : D_SCALED_W) + 2;

  logic signed [PROD_W-1:0] prod [NUM_AXES];
  logic signed [PROD_W-1:0] n_ext;
  logic signed [PROD_W-1:0] c_ext;
  logic signed [PROD_W-1:0] lo_ext;
  logic signed [PROD_W-1:0] hi_ext;
  logic signed [DIST_W-1:0] dist_sum;
  logic signed [DIST_W-1:0] r_scaled;

  // One product per axis; a box takes the corner that maximises the term.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      n_ext  = PROD_W'($signed(plane_i[a*FIELD_W +: FIELD_W]));
      lo_ext = PROD_W'($signed(lo_i[a]));
      hi_ext = PROD_W'($signed(hi_i[a]));
      c_ext  = lo_ext;
      if (kind_i == KIND_BOX) begin
        if (n_ext < 0) begin
          c_ext = (hi_ext < lo_ext) ? hi_ext : lo_ext;
        end else begin
          c_ext = (hi_ext > lo_ext) ? hi_ext : lo_ext;
        end
      end
      prod[a] = n_ext * c_ext;
    end
  end

  // Distance carries 22 fraction bits, so d and the radius are scaled up.
  assign dist_sum = DIST_W'(prod[0]) + DIST_W'(prod[1]) + DIST_W'(prod[2])
                  + (DIST_W'($signed(plane_i[NUM_AXES*FIELD_W +: FIELD_W]))
                     <<< NORMAL_FRAC_BITS);
  assign r_scaled = DIST_W'({1'b0, radius_i}) <<< NORMAL_FRAC_BITS;

  // Reject rule for the requested test.
  always_comb begin
    case (kind_i)
      KIND_POINT:  reject_o = (dist_sum < 0);
      KIND_SPH_IN: reject_o = (dist_sum < r_scaled);
      KIND_SPH_X:  reject_o = (dist_sum < -r_scaled);
      KIND_BOX:    reject_o = (dist_sum <= 0);
      default:     reject_o = (dist_sum <= 0);
    endcase
  end

endmodule

@@ sv/frustum_cull_test.sv @@
// Frustum culling test: top level with input and result registers.
//
// Usage: software loads the six planes (near, far, left, right, up, down)
// and the z check enable through the configuration channel (cfg_valid_i,
// cfg_index_i, cfg_data_i; cfg_ready_o is always high) while no request
// is in flight. Each plane is nx, ny, nz in Q2.14 and d in Q8.8.
// A request enters on the s_axis channel: kind in s_axis_tuser, the
// coordinates and radius in s_axis_tdata. One pass bit comes back on the
// m_axis channel for every request, in order.
// An accepted request goes into the input register and from there into
// the result register, which drives m_axis. Throughput: one request per
// cycle while m_axis_tready stays high; all six plane tests run side by
// side in one pass of eighteen multipliers between the two registers.
// Reset clears both stages, zeroes the planes and enables the z check.
// When m_axis_tready is low the result register holds; the input register
// still takes one more request, then s_axis_tready drops until the
// receiver takes the waiting result.
module frustum_cull_test #(
  parameter int COORD_WIDTH = fcull_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write channel.
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [fcull_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [fcull_pkg::PLANE_W-1:0]          cfg_data_i,
  // Request stream.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata from bit 0: pos_x, pos_y, pos_z, radius, box_max_x, box_max_y,
  // box_max_z, zero padding to whole bytes.
  input  logic [((7*COORD_WIDTH-1+7)/8)*8-1:0]   s_axis_tdata,
  // tuser from bit 0: kind.
  input  logic [fcull_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
  // Result stream.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tdata from bit 0: pass, zero padding.
  output logic [fcull_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import fcull_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int RAD_W = COORD_WIDTH - 1;
  localparam int RAD_LSB = 3*CW;
  localparam int HI_LSB  = 3*CW + RAD_W;

  cfg_wr_t                             cfg_wr;
  logic [NUM_PLANES-1:0][PLANE_W-1:0]  planes;
  logic                                z_check;

  logic                                in_valid_q, in_valid_d;
  kind_e                               kind_q;
  logic [NUM_AXES-1:0][CW-1:0]         lo_q;
  logic [NUM_AXES-1:0][CW-1:0]         hi_q;
  logic [RAD_W-1:0]                    radius_q;

  logic                                out_valid_q, out_valid_d;
  logic                                pass_q;
  logic                                pass_d;
  logic                                out_ready;
  logic [NUM_PLANES-1:0]               reject;
  logic [NUM_PLANES-1:0]               plane_mask;

  // Configuration registers.
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.wr    = cfg_valid_i && cfg_ready_o;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  fcull_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_wr),
    .planes_o  (planes),
    .z_check_o (z_check)
  );

  // Handshake: each stage moves when the one after it is free or draining.
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign in_valid_d    = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d   = out_ready ? in_valid_q : out_valid_q;

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register: unpack the request fields.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q   <= kind_e'(s_axis_tuser);
      radius_q <= s_axis_tdata[RAD_LSB +: RAD_W];
      for (int a = 0; a < NUM_AXES; a++) begin
        lo_q[a] <= s_axis_tdata[a*CW +: CW];
        hi_q[a] <= s_axis_tdata[HI_LSB + a*CW +: CW];
      end
    end
  end

  // One distance test per plane, all in parallel.
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    fcull_plane_test #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_test (
      .plane_i  (planes[p]),
      .kind_i   (kind_q),
      .lo_i     (lo_q),
      .hi_i     (hi_q),
      .radius_i (radius_q),
      .reject_o (reject[p])
    );
  end

  // Near and far planes drop out when the z check is off.
  always_comb begin
    plane_mask = '1;
    if (!z_check) begin
      plane_mask[PLANE_NEAR] = 1'b0;
      plane_mask[PLANE_FAR]  = 1'b0;
    end
  end

  assign pass_d = ~|(reject & plane_mask);

  // Result register.
  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      pass_q <= pass_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(pass_q);

  `FC_ASSERT(a_accept_fills_input, s_axis_tvalid && s_axis_tready |=> in_valid_q)
  `FC_ASSERT(a_full_blocks_input, out_valid_q && !m_axis_tready && in_valid_q |-> !s_axis_tready)
  `FC_ASSERT(a_input_moves_on, in_valid_q && out_ready |=> m_axis_tvalid)
  `FC_ASSERT(a_stall_keeps_input, in_valid_q && !out_ready |=> in_valid_q && $stable(kind_q))
  `FC_ASSERT_NR(a_reset_empty, !rst_ni |-> !in_valid_q && !out_valid_q)

endmodule

@@ verif/frustum_cull_test_test.sv @@
// Self-checking testbench for the frustum culling block, with a predictor and random stimulus.
`timescale 1ns / 100ps

module frustum_cull_test_test;
  import fcull_pkg::*;

  localparam int COORD_W    = COORD_WIDTH_DEF;
  localparam int IN_TDATA_W = ((7*COORD_W-1+7)/8)*8;
  localparam int UNIT       = 1 << NORMAL_FRAC_BITS;
  localparam int PHASE_LEN  = 220;

  // One primitive as it travels on the request stream.
  typedef struct packed {
    kind_e                       kind;
    logic [COORD_W-2:0]          radius;
    logic [NUM_AXES-1:0][COORD_W-1:0] pos;
    logic [NUM_AXES-1:0][COORD_W-1:0] bmax;
  } prim_t;

  // Keeps a copy of the plane registers, predicts the verdict for every
  // accepted request and checks the verdicts in order.
  class verdict_board;
    logic [PLANE_W-1:0] planes [NUM_PLANES];
    bit                 z_check;
    bit                 verdicts_q [$];
    int unsigned        mismatches;

    function new();
      foreach (planes[i]) planes[i] = '0;
      z_check    = 1'b1;
      mismatches = 0;
    endfunction

    // Out-of-range indexes are dropped, as in the block.
    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [PLANE_W-1:0] data);
      if (idx <= CFG_PLANE_DOWN) begin
        planes[idx] = data;
      end else if (idx == CFG_Z_CHECK) begin
        z_check = data[0];
      end
    endfunction

    // Exact signed distances; the radius and d carry the normal's fraction bits.
    function bit predict_pass(prim_t p);
      longint reach;
      longint r_scaled;
      longint n;
      longint t_lo;
      longint t_hi;
      int     first;
      bit     verdict;
      r_scaled = longint'(p.radius) <<< NORMAL_FRAC_BITS;
      first    = z_check ? PLANE_NEAR : PLANE_FAR + 1;
      verdict  = 1'b1;
      for (int i = first; i < NUM_PLANES; i++) begin
        reach = longint'($signed(planes[i][NUM_AXES*FIELD_W +: FIELD_W])) <<< NORMAL_FRAC_BITS;
        for (int a = 0; a < NUM_AXES; a++) begin
          n    = longint'($signed(planes[i][a*FIELD_W +: FIELD_W]));
          t_lo = n * longint'($signed(p.pos[a]));
          t_hi = n * longint'($signed(p.bmax[a]));
          // A box takes the corner that lies furthest along the normal.
          if (p.kind == KIND_BOX && t_hi > t_lo) begin
            reach += t_hi;
          end else begin
            reach += t_lo;
          end
        end
        case (p.kind)
          KIND_POINT:  if (reach < 0) verdict = 1'b0;
          KIND_SPH_IN: if (reach < r_scaled) verdict = 1'b0;
          KIND_SPH_X:  if (reach < -r_scaled) verdict = 1'b0;
          default:     if (reach <= 0) verdict = 1'b0;
        endcase
      end
      return verdict;
    endfunction

    function void note_primitive(prim_t p);
      verdicts_q.push_back(predict_pass(p));
    endfunction

    function void check_verdict(logic got);
      bit want;
      if (verdicts_q.size() == 0) begin
        $display("%0t: verdict %b arrived with no request waiting", $time, got);
        mismatches++;
      end else begin
        want = verdicts_q.pop_front();
        if (got !== want) begin
          $display("%0t: pass expected %b, actual %b", $time, want, got);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return verdicts_q.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_INDEX_W-1:0]  cfg_index_i = CFG_PLANE_NEAR;
  logic [PLANE_W-1:0]      cfg_data_i = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]   s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;

  verdict_board       board;
  bit                 steady = 1'b0;
  logic [PLANE_W-1:0] plane_set [NUM_PLANES];

  frustum_cull_test #(
    .COORD_WIDTH(COORD_W)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Packs one plane: nx, ny, nz from the lowest bits up, then d.
  function automatic logic [PLANE_W-1:0] plane_of(int nx, int ny, int nz, int d);
    return {d[FIELD_W-1:0], nz[FIELD_W-1:0], ny[FIELD_W-1:0], nx[FIELD_W-1:0]};
  endfunction

  // Mostly values near the frustum, now and then anything at all.
  function automatic logic [COORD_W-1:0] rand_coord(int spread);
    if ($urandom_range(0, 3) == 0) begin
      return COORD_W'($urandom);
    end
    return COORD_W'(int'($urandom_range(0, 2*spread)) - spread);
  endfunction

  function automatic prim_t random_prim(int spread);
    prim_t p;
    int    extent;
    int    rad_top;
    p.kind  = kind_e'($urandom_range(KIND_POINT, KIND_BOX));
    rad_top = (spread / 2 > 32767) ? 32767 : spread / 2;
    p.radius = ($urandom_range(0, 7) == 0) ? (COORD_W-1)'($urandom)
                                           : (COORD_W-1)'($urandom_range(0, rad_top));
    for (int a = 0; a < NUM_AXES; a++) begin
      p.pos[a] = rand_coord(spread);
      extent   = $urandom_range(0, spread);
      case ($urandom_range(0, 7))
        0:       p.bmax[a] = COORD_W'($urandom);
        1:       p.bmax[a] = COORD_W'(int'($signed(p.pos[a])) - extent);
        default: p.bmax[a] = COORD_W'(int'($signed(p.pos[a])) + extent);
      endcase
    end
    return p;
  endfunction

  // Offers one request and returns at the edge that takes it.
  task automatic send_item(prim_t p);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= p.kind;
    s_axis_tdata  <= {1'b0, p.bmax[2], p.bmax[1], p.bmax[0], p.radius,
                      p.pos[2], p.pos[1], p.pos[0]};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_primitive(p);
  endtask

  task automatic send_prim(kind_e k, int px, int py, int pz, int r,
                           int bx, int by, int bz);
    prim_t p;
    p.kind    = k;
    p.radius  = r[COORD_W-2:0];
    p.pos[0]  = px[COORD_W-1:0];
    p.pos[1]  = py[COORD_W-1:0];
    p.pos[2]  = pz[COORD_W-1:0];
    p.bmax[0] = bx[COORD_W-1:0];
    p.bmax[1] = by[COORD_W-1:0];
    p.bmax[2] = bz[COORD_W-1:0];
    send_item(p);
  endtask

  // Stops offering and waits until every verdict has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [PLANE_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
  endtask

  // Loads plane_set and the z check; the spare index gets junk that must be ignored.
  task automatic load_planes(bit zc);
    logic [PLANE_W-1:0] word;
    for (int i = 0; i < NUM_PLANES; i++) begin
      write_reg(CFG_PLANE_NEAR + CFG_INDEX_W'(i), plane_set[i]);
    end
    word    = {$urandom, $urandom};
    word[0] = zc;
    write_reg(CFG_Z_CHECK, word);
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
  endtask

  // An axis-aligned cube of half size half around the origin.
  task automatic set_box(int half, bit zc);
    plane_set[PLANE_NEAR]      = plane_of(0, 0, UNIT, half);
    plane_set[PLANE_FAR]       = plane_of(0, 0, -UNIT, half);
    plane_set[CFG_PLANE_LEFT]  = plane_of(UNIT, 0, 0, half);
    plane_set[CFG_PLANE_RIGHT] = plane_of(-UNIT, 0, 0, half);
    plane_set[CFG_PLANE_UP]    = plane_of(0, -UNIT, 0, half);
    plane_set[CFG_PLANE_DOWN]  = plane_of(0, UNIT, 0, half);
    load_planes(zc);
  endtask

  // Random requests, with one full pause half way through.
  task automatic run_random(int count, int spread);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 63) == 0) steady = ~steady;
      if (k == count / 2) drain();
      send_item(random_prim(spread));
    end
  endtask

  // Result side: random stalls, one verdict checked per handshake.
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_verdict(m_axis_tdata[0]);
    end
  end

  // Slowest run is some 1600 requests.
  initial begin
    #2000000;
    $display("FAIL frustum_cull_test");
    $finish;
  end

  initial begin
    int spread;
    rst_ni <= 1'b0;
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Planes at reset zero: points, crossing spheres, radius-0 inside sphere pass; rest fail.
    send_prim(KIND_POINT, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
    send_prim(KIND_POINT, 32767, 32767, 32767, 0, -32768, -32768, -32768);
    send_prim(KIND_SPH_IN, 0, 0, 0, 0, 0, 0, 0);
    send_prim(KIND_SPH_IN, 0, 0, 0, 32767, 0, 0, 0);
    send_prim(KIND_SPH_X, 0, 0, 0, 32767, 0, 0, 0);
    send_prim(KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
    drain();

    // Cube of half size 64.0; most cases sit exactly on or just past the left plane.
    set_box(16384, 1'b1);
    send_prim(KIND_POINT, 0, 0, 0, 32767, -1, -1, -1);
    send_prim(KIND_POINT, -16384, 0, 0, 0, 0, 0, 0);
    send_prim(KIND_POINT, -16385, 0, 0, 0, 0, 0, 0);
    send_prim(KIND_POINT, 0, 0, 20000, 0, 0, 0, 0);
    send_prim(KIND_SPH_IN, 0, 0, 0, 16384, 32767, 32767, 32767);
    send_prim(KIND_SPH_IN, 0, 0, 0, 16385, 0, 0, 0);
    send_prim(KIND_SPH_X, -32768, 0, 0, 16384, 0, 0, 0);
    send_prim(KIND_SPH_X, -32768, 0, 0, 16383, 0, 0, 0);
    send_prim(KIND_BOX, -32768, -256, -256, 32767, -16384, 256, 256);
    send_prim(KIND_BOX, -32768, -256, -256, 0, -16383, 256, 256);
    send_prim(KIND_BOX, 100, 100, 100, 0, -100, -100, -100);
    send_prim(KIND_BOX, 20000, -256, -256, 0, 32767, 256, 256);
    send_prim(KIND_BOX, -32768, -32768, -32768, 0, 32767, 32767, 32767);
    drain();

    // Random phases over several plane sets, the register extremes among them.
    for (int ph = 0; ph < 7; ph++) begin
      spread = 32767;
      case (ph)
        0: begin
          set_box(16384, 1'b1);
          spread = 24576;
        end
        1: begin
          spread = $urandom_range(256, 16384);
          set_box(spread, 1'b0);
          spread = spread + spread / 2;
        end
        2, 3: begin
          for (int i = 0; i < NUM_PLANES; i++) begin
            plane_set[i] = plane_of(int'($urandom_range(0, 2*UNIT)) - UNIT,
                                    int'($urandom_range(0, 2*UNIT)) - UNIT,
                                    int'($urandom_range(0, 2*UNIT)) - UNIT,
                                    $urandom_range(4096, 32767));
          end
          load_planes(ph == 2);
          spread = 8192;
        end
        4: begin
          foreach (plane_set[i]) plane_set[i] = '1;
          load_planes(1'b1);
        end
        5: begin
          foreach (plane_set[i]) plane_set[i] = 64'h7FFF_7FFF_7FFF_7FFF;
          load_planes(1'b0);
        end
        default: begin
          foreach (plane_set[i]) plane_set[i] = {$urandom, $urandom};
          plane_set[PLANE_NEAR] = 64'h8000_8000_8000_8000;
          load_planes(1'b1);
        end
      endcase
      run_random(PHASE_LEN, spread);
      drain();
    end

    // Room for any stray verdict to show up.
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("PASS frustum_cull_test");
    end else begin
      $display("FAIL frustum_cull_test");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/fcull_pkg.sv
sv/fcull_cfg_regs.sv
sv/fcull_plane_test.sv
sv/frustum_cull_test.sv
verif/frustum_cull_test_test.sv
